// ----- src/ffec_pkg.sv -----
`default_nettype none

package ffec_pkg;

  localparam int unsigned FLOORS      = 4;
  localparam int unsigned DWELL_W     = 9;
  localparam int unsigned STATE_W     = 4;

  typedef logic [FLOORS-1:0]  floor_vec_t;
  typedef logic [DWELL_W-1:0] dwell_t;
  typedef logic [STATE_W-1:0] state_code_t;

  // dwell time after reset, in ticks
  localparam dwell_t DWELL_RESET = dwell_t'(300);

endpackage

`default_nettype wire

// ----- src/four_floor_elevator_controller_top.sv -----
// four-floor elevator controller, one 10 ms tick per input word
//
// input channel (in_valid / in_stall): one word per tick with the four call
// buttons and the four floor limit switches. the word is accepted on a rising
// edge with in_valid high and in_stall low.
// result channel (out_valid / out_stall): one word per accepted tick with the
// call lamps, the motor drives and the cabin state number, all as they stood
// before that tick's update. taken on a rising edge with out_valid high and
// out_stall low.
// config channel (cfg_valid / cfg_ready): writes dwell_ticks, always ready.
// a write only affects later arrivals, never a running dwell count.
// the result word is registered, valid in the cycle after its tick is taken.
// throughput: one tick per cycle while no result is stalled; the state update
// for a tick is a single pass of logic into the state and result registers.
// stall: while the result register is full and stalled, in_stall is high and
// no tick is taken; a tick is taken in the same cycle the held result leaves.
// reset: cabin idle at floor one, no calls pending, dwell count zero,
// dwell_ticks back to 300, result register empty.
`default_nettype none

module four_floor_elevator_controller_top (
  input  wire                        clk,
  input  wire                        rst_n,
  // tick input
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  ffec_pkg::floor_vec_t in_call_buttons,
  input  wire  ffec_pkg::floor_vec_t in_floor_switches,
  // result output
  output logic                       out_valid,
  input  wire                        out_stall,
  output ffec_pkg::floor_vec_t       out_call_lamps,
  output logic                       out_motor_up,
  output logic                       out_motor_down,
  output ffec_pkg::state_code_t      out_cabin_state,
  // dwell register write
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  ffec_pkg::dwell_t     cfg_dwell_ticks
);
  import ffec_pkg::*;

  // cabin machine: idle-at-floor, stopping moves and pass-through moves
  typedef enum logic [STATE_W-1:0] {
    IDLE_F1      = 4'd1,
    UP_STOP_F2   = 4'd2,
    UP_PASS_F2   = 4'd3,
    IDLE_F2      = 4'd4,
    DN_STOP_F1   = 4'd5,
    UP_STOP_F3   = 4'd6,
    UP_PASS_F3   = 4'd7,
    IDLE_F3      = 4'd8,
    UP_STOP_F4   = 4'd9,
    DN_STOP_F2   = 4'd10,
    DN_PASS_F2   = 4'd11,
    IDLE_F4      = 4'd12,
    DN_STOP_F3   = 4'd13,
    DN_PASS_F3   = 4'd14
  } cabin_t;

  cabin_t     mode_r, mode_nxt;
  floor_vec_t pend_r, pend_nxt;
  dwell_t     dwell_cnt_r, dwell_cnt_nxt;
  dwell_t     dwell_ticks_r;

  logic       in_take;
  logic       out_take;
  logic       up, down, load;
  logic       dwell_done;
  dwell_t     dwell_loaded;

  logic c1, c2, c3, c4, k1, k2, k3, k4;

  // result register frees up in the cycle its word is taken
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign c1 = pend_r[0];
  assign c2 = pend_r[1];
  assign c3 = pend_r[2];
  assign c4 = pend_r[3];
  assign k1 = in_floor_switches[0];
  assign k2 = in_floor_switches[1];
  assign k3 = in_floor_switches[2];
  assign k4 = in_floor_switches[3];

  assign dwell_done = (dwell_cnt_r == '0);

  // calls latch on a button, drop on the floor's switch
  assign pend_nxt = (pend_r & ~in_floor_switches) | (~pend_r & in_call_buttons);

  always_comb begin
    mode_nxt = mode_r;
    up       = 1'b0;
    down     = 1'b0;
    load     = 1'b0;
    case (mode_r)
      IDLE_F1: begin
        if (c2 && dwell_done) mode_nxt = UP_STOP_F2;
        else if (!c2 && (c3 || c4) && dwell_done) mode_nxt = UP_PASS_F2;
      end
      UP_STOP_F2: begin
        up = 1'b1;
        if (k2) begin
          load     = 1'b1;
          mode_nxt = IDLE_F2;
        end
      end
      UP_PASS_F2: begin
        up = 1'b1;
        if (k2) mode_nxt = IDLE_F2;
      end
      IDLE_F2: begin
        if (c1 && dwell_done) mode_nxt = DN_STOP_F1;
        else if (!c1 && c3 && dwell_done) mode_nxt = UP_STOP_F3;
        else if (!c1 && !c3 && c4 && dwell_done) mode_nxt = UP_PASS_F3;
      end
      DN_STOP_F1: begin
        down = 1'b1;
        if (k1) begin
          load     = 1'b1;
          mode_nxt = IDLE_F1;
        end
      end
      UP_STOP_F3: begin
        up = 1'b1;
        if (k3) begin
          load     = 1'b1;
          mode_nxt = IDLE_F3;
        end
      end
      UP_PASS_F3: begin
        up = 1'b1;
        if (k3) mode_nxt = IDLE_F3;
      end
      IDLE_F3: begin
        if (c4 && dwell_done) mode_nxt = UP_STOP_F4;
        else if (!c4 && c2 && dwell_done) mode_nxt = DN_STOP_F2;
        else if (c1 && !c2 && !c4 && dwell_done) mode_nxt = DN_PASS_F2;
      end
      UP_STOP_F4: begin
        up = 1'b1;
        if (k4) begin
          load     = 1'b1;
          mode_nxt = IDLE_F4;
        end
      end
      DN_STOP_F2: begin
        down = 1'b1;
        if (k2) begin
          load     = 1'b1;
          mode_nxt = IDLE_F2;
        end
      end
      DN_PASS_F2: begin
        down = 1'b1;
        if (k2) mode_nxt = IDLE_F2;
      end
      IDLE_F4: begin
        if (c3 && dwell_done) mode_nxt = DN_STOP_F3;
        else if ((c1 || c2) && !c3 && dwell_done) mode_nxt = DN_PASS_F3;
      end
      DN_STOP_F3: begin
        down = 1'b1;
        if (k3) begin
          load     = 1'b1;
          mode_nxt = IDLE_F3;
        end
      end
      DN_PASS_F3: begin
        down = 1'b1;
        if (k3) mode_nxt = IDLE_F3;
      end
      default: begin
        // unreachable codes hold with both motors off
        mode_nxt = mode_r;
      end
    endcase
  end

  // a fresh load is counted down in the same tick
  assign dwell_loaded  = load ? dwell_ticks_r : dwell_cnt_r;
  assign dwell_cnt_nxt = (dwell_loaded != '0) ? dwell_loaded - dwell_t'(1) : dwell_loaded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= IDLE_F1;
      pend_r        <= '0;
      dwell_cnt_r   <= '0;
      dwell_ticks_r <= DWELL_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dwell_ticks_r <= cfg_dwell_ticks;
      end
      if (in_take) begin
        mode_r      <= mode_nxt;
        pend_r      <= pend_nxt;
        dwell_cnt_r <= dwell_cnt_nxt;
        out_valid   <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, sampled from the state before the update
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_call_lamps  <= pend_r;
      out_motor_up    <= up;
      out_motor_down  <= down;
      out_cabin_state <= state_code_t'(mode_r);
    end
  end

  // an accepted tick always leaves a result word behind
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid)
    else $error("accepted tick produced no result word");

  // a held result is never overwritten while stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cabin_state)
                                  && $stable(out_call_lamps)))
    else $error("stalled result word changed");

  // dwell only runs while the cabin stands at a floor
  a_dwell_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (dwell_cnt_r != '0) |-> (mode_r == IDLE_F1 || mode_r == IDLE_F2 ||
                             mode_r == IDLE_F3 || mode_r == IDLE_F4))
    else $error("dwell count running while cabin is moving");

  // never drive both directions at once
  a_motor_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_motor_up && out_motor_down))
    else $error("both motor drives active");

endmodule

`default_nettype wire
